// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

// ===== rtl/mvt_pkg.sv =====
package mvt_pkg;

  // Widths of the data path.
  localparam int DATA_W            = 32;
  localparam int PROD_W            = 2 * DATA_W;
  localparam int SUM_W             = PROD_W + 2;
  localparam int DIM               = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Sixteen coefficients, entry col*4+row.
  typedef coef_t [DIM*DIM-1:0] coef_mat_t;
  // Four vector components, x at index 0.
  typedef coef_t [DIM-1:0] vec_t;
  // Products indexed [row][column].
  typedef prod_t [DIM-1:0][DIM-1:0] prod_mat_t;

  // Write port of the coefficient store.
  typedef struct packed {
    logic        en;
    logic [1:0]  col;
    logic [1:0]  row;
    coef_t       value;
  } coef_wr_t;

endpackage

// ===== rtl/mat4_vector_transform_core.sv =====
// Channel   Handshake             Word
// input     in_valid / in_ready   kind, coef_col, coef_row, coef_value, vec_x..vec_w
// output    out_valid / out_ready out_x, out_y, out_z, out_w, clipped
//
// One word is accepted per cycle unless the pipeline stalls. A transform word passes the
// input, product and result registers; its result is offered from the result register.
// A load word gives no result; it writes its coefficient when it leaves the
// input register, so later transforms see it and earlier ones do not.
// Reset restores the identity matrix and empties all stages at once.
// Each stage holds a transform word while the one after it is full and stalled.
module mat4_vector_transform_core #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [1:0]                coef_col,
  input  logic [1:0]                coef_row,
  input  logic signed [mvt_pkg::DATA_W-1:0] coef_value,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_x,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_y,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_z,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_w,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                      clipped
);

  logic                a_valid;
  logic                a_kind;
  logic [1:0]          a_col;
  logic [1:0]          a_row;
  mvt_pkg::coef_t      a_value;
  mvt_pkg::vec_t       a_vec;
  logic                a_adv;
  logic                a_ready;

  logic                mul_in_valid;
  logic                mul_in_ready;
  logic                mul_out_valid;
  logic                sum_in_ready;
  mvt_pkg::prod_mat_t  prods;
  mvt_pkg::coef_mat_t  coefs;
  mvt_pkg::coef_wr_t   wr;
  mvt_pkg::vec_t       result;

  // Input register: a load always leaves; a transform waits for the product stage.
  assign mul_in_valid = a_valid && (a_kind == mvt_pkg::KIND_XFORM);
  assign a_adv        = a_valid && ((a_kind == mvt_pkg::KIND_LOAD) || mul_in_ready);
  assign a_ready      = !a_valid || a_adv;
  assign in_ready     = a_ready;

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_kind   <= kind;
      a_col    <= coef_col;
      a_row    <= coef_row;
      a_value  <= coef_value;
      a_vec[0] <= vec_x;
      a_vec[1] <= vec_y;
      a_vec[2] <= vec_z;
      a_vec[3] <= vec_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  // Coefficient write as the load word leaves the input register.
  assign wr.en    = a_valid && (a_kind == mvt_pkg::KIND_LOAD);
  assign wr.col   = a_col;
  assign wr.row   = a_row;
  assign wr.value = a_value;

  mvt_coef_store #(
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .coefs (coefs)
  );

  mvt_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_in_valid),
    .in_ready  (mul_in_ready),
    .vec       (a_vec),
    .coefs     (coefs),
    .out_valid (mul_out_valid),
    .out_ready (sum_in_ready),
    .prods     (prods)
  );

  mvt_sum_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_out_valid),
    .in_ready  (sum_in_ready),
    .prods     (prods),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .clip      (clipped)
  );

  assign out_x = result[0];
  assign out_y = result[1];
  assign out_z = result[2];
  assign out_w = result[3];

endmodule

// ===== rtl/mvt_coef_store.sv =====
module mvt_coef_store #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mvt_pkg::coef_wr_t wr,
  output mvt_pkg::coef_mat_t coefs
);

  localparam logic [mvt_pkg::DATA_W-1:0] ONE = mvt_pkg::DATA_W'(1) << FRAC_BITS;

  mvt_pkg::coef_mat_t mat;

  // Reset loads the identity matrix; a load word overwrites one entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < mvt_pkg::DIM * mvt_pkg::DIM; e++) begin
        mat[e] <= ((e >> 2) == (e & 3)) ? ONE : '0;
      end
    end else if (wr.en) begin
      mat[{wr.col, wr.row}] <= wr.value;
    end
  end

  assign coefs = mat;

endmodule

// ===== rtl/mvt_mul_stage.sv =====
module mvt_mul_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvt_pkg::vec_t       vec,
  input  mvt_pkg::coef_mat_t  coefs,
  output logic                out_valid,
  input  logic                out_ready,
  output mvt_pkg::prod_mat_t  prods
);

  logic               valid;
  mvt_pkg::prod_mat_t prod_next;
  mvt_pkg::prod_mat_t prod_reg;

  assign in_ready = !valid || out_ready;

  // Sixteen independent products, coefficient [col][row] times component col.
  always_comb begin
    logic signed [mvt_pkg::DATA_W-1:0] c;
    logic signed [mvt_pkg::DATA_W-1:0] v;
    logic signed [mvt_pkg::PROD_W-1:0] p;
    prod_next = '0;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        c = coefs[i * mvt_pkg::DIM + r];
        v = vec[i];
        p = c * v;
        prod_next[r][i] = p;
      end
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_reg <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  assign out_valid = valid;
  assign prods     = prod_reg;

endmodule

// ===== rtl/mvt_sum_stage.sv =====
module mvt_sum_stage #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mvt_pkg::prod_mat_t prods,
  output logic               out_valid,
  input  logic               out_ready,
  output mvt_pkg::vec_t      result,
  output logic               clip
);

  localparam int HI_W = mvt_pkg::SUM_W - mvt_pkg::DATA_W + 1;
  localparam logic [mvt_pkg::DATA_W-1:0] MAX_VAL = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
  localparam logic [mvt_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};

  logic          valid;
  mvt_pkg::vec_t res_next;
  logic          clip_next;
  mvt_pkg::vec_t res_reg;
  logic          clip_reg;

  assign in_ready = !valid || out_ready;

  // Exact row sums, floor shift and saturation to 32 bits.
  always_comb begin
    logic signed [mvt_pkg::SUM_W-1:0] sum;
    logic signed [mvt_pkg::SUM_W-1:0] shifted;
    logic        [HI_W-1:0]           hi;
    logic        [mvt_pkg::PROD_W-1:0] p;
    res_next  = '0;
    clip_next = 1'b0;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      sum = '0;
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        p   = prods[r][i];
        sum = sum + $signed({{2{p[mvt_pkg::PROD_W-1]}}, p});
      end
      shifted = sum >>> FRAC_BITS;
      hi      = shifted[mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1];
      if ((&hi) || !(|hi)) begin
        res_next[r] = shifted[mvt_pkg::DATA_W-1:0];
      end else begin
        res_next[r] = shifted[mvt_pkg::SUM_W-1] ? MIN_VAL : MAX_VAL;
        clip_next   = 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_reg  <= res_next;
      clip_reg <= clip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  assign out_valid = valid;
  assign result    = res_reg;
  assign clip      = clip_reg;

endmodule

// ===== rtl/mvt_checker.sv =====
`include "assert_macros.svh"

module mvt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mvt_pkg::DATA_W-1:0] out_x,
  input logic signed [mvt_pkg::DATA_W-1:0] out_y,
  input logic signed [mvt_pkg::DATA_W-1:0] out_z,
  input logic signed [mvt_pkg::DATA_W-1:0] out_w,
  input logic                              clipped
);

  localparam logic [mvt_pkg::DATA_W-1:0] MAX_VAL = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
  localparam logic [mvt_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};

  logic x_ext;
  logic y_ext;
  logic z_ext;
  logic w_ext;
  logic [4*mvt_pkg::DATA_W:0] out_word;

  assign x_ext = (out_x == MAX_VAL) || (out_x == MIN_VAL);
  assign y_ext = (out_y == MAX_VAL) || (out_y == MIN_VAL);
  assign z_ext = (out_z == MAX_VAL) || (out_z == MIN_VAL);
  assign w_ext = (out_w == MAX_VAL) || (out_w == MIN_VAL);

  // The whole result word, for the stability check.
  assign out_word = {out_x, out_y, out_z, out_w, clipped};

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // A stalled result keeps its value.
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_word))
  // A clipped result has at least one component at a saturation limit.
  `ASSERT_IMPLIES(a_clip_limit, clk, rst, out_valid && clipped, x_ext || y_ext || z_ext || w_ext)
  // Reset empties the pipeline, so no result is offered right after it.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind mat4_vector_transform_core mvt_checker u_mvt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .out_w     (out_w),
  .clipped   (clipped)
);
